// ----- rtl/rsm_pkg.sv -----
// shared types and constants of the raid stripe request mapper
// no dependencies; used by every rtl file of the block
package rsm_pkg;

	localparam int DISK_W = 5;    // member disk index, up to 32 disks
	localparam int NUM_W = 6;     // member disk count
	localparam int ADDR_W = 48;
	localparam int STRIP_W = 17;  // strip size in blocks
	localparam int OFF_W = 16;
	localparam int CNT_W = 13;
	localparam int REL_W = 6;
	localparam int QUEUE_DEPTH = 2;  // power of two

	localparam int DEF_MAX_DISKS = 16;
	localparam int DEF_MAX_REQUEST_BLOCKS = 4096;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_RDONLY = 2'd2;

	localparam logic [2:0] LAY_R4_FIRST = 3'd0;
	localparam logic [2:0] LAY_R4_LAST = 3'd1;
	localparam logic [2:0] LAY_R5_0R = 3'd2;
	localparam logic [2:0] LAY_R5_NR = 3'd3;
	localparam logic [2:0] LAY_R5_NC = 3'd4;

	localparam logic [2:0] REG_EXTENT = 3'd0;
	localparam logic [2:0] REG_STRIP = 3'd1;
	localparam logic [2:0] REG_LAYOUT = 3'd2;
	localparam logic [2:0] REG_DOFF = 3'd3;
	localparam logic [2:0] REG_VOLUME = 3'd4;
	localparam logic [2:0] REG_RDONLY = 3'd5;

	typedef struct packed {
		logic [NUM_W-1:0]   n;
		logic [STRIP_W-1:0] sb;
		logic [2:0]         mode;
		logic [31:0]        doff;
		logic [ADDR_W-1:0]  vol;
		logic               ro;
	} rsm_cfg_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ADDR_W-1:0]  base;     // first stripe times strip size plus data offset
		logic [OFF_W-1:0]   off0;
		logic [CNT_W-1:0]   cnt;
		logic [DISK_W-1:0]  pos0;
		logic [DISK_W-1:0]  rot0;
		logic [DISK_W-1:0]  pos_last;
		logic [REL_W-1:0]   last_rel;
		logic [OFF_W-1:0]   lo_last;
	} rsm_job_t;

endpackage

// ----- rtl/rsm_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on rsm_pkg
module rsm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rsm_pkg::ADDR_W-1:0]  num,
	input  logic [rsm_pkg::STRIP_W-1:0] den,
	output logic                        done,
	output logic [rsm_pkg::ADDR_W-1:0]  quo,
	output logic [rsm_pkg::STRIP_W-1:0] rem
);
	import rsm_pkg::*;

	localparam int CW = $clog2(ADDR_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [ADDR_W-1:0]  num_q;
	logic [STRIP_W-1:0] rem_q;
	logic [STRIP_W-1:0] den_q;
	logic [STRIP_W:0]   trial;
	logic               ge;

	assign trial = {rem_q, num_q[ADDR_W-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ADDR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? STRIP_W'(trial - {1'b0, den_q}) : trial[STRIP_W-1:0];
			num_q <= {num_q[ADDR_W-2:0], ge};
		end else if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end
	end

	assign done = done_q;
	assign quo = num_q;
	assign rem = rem_q;
endmodule

// ----- rtl/rsm_front.sv -----
// front end: takes a request, checks it and works out its stripe geometry
// depends on rsm_pkg and rsm_div
module rsm_front #(
	parameter int MAX_REQUEST_BLOCKS = rsm_pkg::DEF_MAX_REQUEST_BLOCKS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsm_pkg::rsm_cfg_t          cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [rsm_pkg::ADDR_W-1:0] start_block,
	input  logic [rsm_pkg::CNT_W-1:0]  block_count,
	input  logic                       q_full,
	output logic                       q_push,
	output rsm_pkg::rsm_job_t          q_job
);
	import rsm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_D1 = 3'd1;
	localparam logic [2:0] S_D2 = 3'd2;
	localparam logic [2:0] S_D3 = 3'd3;
	localparam logic [2:0] S_D4 = 3'd4;
	localparam logic [2:0] S_D5 = 3'd5;
	localparam logic [2:0] S_MUL = 3'd6;
	localparam logic [2:0] S_PUSH = 3'd7;
	localparam int MW = $clog2(STRIP_W + 1);
	localparam int RW = $clog2(MAX_REQUEST_BLOCKS + 1) + 1;

	logic [2:0]         st_q;
	logic               start_q;
	logic [1:0]         status_q;
	logic [ADDR_W-1:0]  ba_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  strip0_q;
	logic [ADDR_W-1:0]  stripe0_q;
	logic [OFF_W-1:0]   off0_q;
	logic [DISK_W-1:0]  pos0_q;
	logic [DISK_W-1:0]  rot0_q;
	logic [REL_W-1:0]   q_q;
	logic [OFF_W-1:0]   lo_last_q;
	logic [REL_W-1:0]   last_rel_q;
	logic [DISK_W-1:0]  pos_last_q;
	logic [ADDR_W-1:0]  acc_q;
	logic [ADDR_W-1:0]  mcand_q;
	logic [STRIP_W-1:0] mplier_q;
	logic [MW-1:0]      mcnt_q;

	logic [ADDR_W-1:0]  div_num;
	logic [STRIP_W-1:0] div_den;
	logic               div_done;
	logic [ADDR_W-1:0]  div_quo;
	logic [STRIP_W-1:0] div_rem;
	logic [NUM_W-1:0]   d;
	logic               accept;
	logic               range_bad;
	logic [ADDR_W:0]    end_sum;

	assign d = cfg.n - 1'b1;
	assign in_stall = st_q != S_IDLE;
	assign accept = in_valid && !in_stall;
	assign end_sum = {1'b0, start_block} + (ADDR_W + 1)'(block_count);
	assign range_bad = block_count == '0
		|| RW'(block_count) > RW'(MAX_REQUEST_BLOCKS)
		|| end_sum > {1'b0, cfg.vol};

	always_comb begin
		div_num = '0;
		div_den = STRIP_W'(1);
		unique case (st_q)
			S_D1: begin
				div_num = ba_q;
				div_den = cfg.sb;
			end
			S_D2: begin
				div_num = strip0_q;
				div_den = STRIP_W'(d);
			end
			S_D3: begin
				div_num = stripe0_q;
				div_den = STRIP_W'(cfg.n);
			end
			S_D4: begin
				div_num = ADDR_W'(off0_q) + ADDR_W'(cnt_q) - 1'b1;
				div_den = cfg.sb;
			end
			S_D5: begin
				div_num = ADDR_W'(pos0_q) + ADDR_W'(q_q);
				div_den = STRIP_W'(d);
			end
			default: begin
				div_num = '0;
				div_den = STRIP_W'(1);
			end
		endcase
	end

	rsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						if ((opcode && cfg.ro) || range_bad) begin
							st_q <= S_PUSH;
						end else begin
							st_q <= S_D1;
							start_q <= 1'b1;
						end
					end
				end
				S_D1, S_D2, S_D3, S_D4: begin
					if (div_done) begin
						st_q <= st_q + 1'b1;
						start_q <= 1'b1;
					end
				end
				S_D5: begin
					if (div_done) st_q <= S_MUL;
				end
				S_MUL: begin
					if (mcnt_q == MW'(STRIP_W - 1)) st_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!q_full) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ba_q <= start_block;
			cnt_q <= block_count;
			if (opcode && cfg.ro) status_q <= ST_RDONLY;
			else if (range_bad) status_q <= ST_RANGE;
			else status_q <= ST_OK;
		end
		if (div_done) begin
			case (st_q)
				S_D1: begin
					strip0_q <= div_quo;
					off0_q <= div_rem[OFF_W-1:0];
				end
				S_D2: begin
					stripe0_q <= div_quo;
					pos0_q <= div_rem[DISK_W-1:0];
				end
				S_D3: rot0_q <= div_rem[DISK_W-1:0];
				S_D4: begin
					q_q <= div_quo[REL_W-1:0];
					lo_last_q <= div_rem[OFF_W-1:0];
				end
				default: begin
					last_rel_q <= div_quo[REL_W-1:0];
					pos_last_q <= div_rem[DISK_W-1:0];
				end
			endcase
		end
		// shift-add of first stripe index times strip size, starting from the data offset
		if (st_q == S_D5 && div_done) begin
			acc_q <= ADDR_W'(cfg.doff);
			mcand_q <= stripe0_q;
			mplier_q <= cfg.sb;
			mcnt_q <= '0;
		end else if (st_q == S_MUL) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= {mcand_q[ADDR_W-2:0], 1'b0};
			mplier_q <= mplier_q >> 1;
			mcnt_q <= mcnt_q + 1'b1;
		end
	end

	assign q_push = st_q == S_PUSH && !q_full;

	always_comb begin
		q_job = '0;
		q_job.status = status_q;
		if (status_q == ST_OK) begin
			q_job.base = acc_q;
			q_job.off0 = off0_q;
			q_job.cnt = cnt_q;
			q_job.pos0 = pos0_q;
			q_job.rot0 = rot0_q;
			q_job.pos_last = pos_last_q;
			q_job.last_rel = last_rel_q;
			q_job.lo_last = lo_last_q;
		end
	end
endmodule

// ----- rtl/rsm_queue.sv -----
// short job queue between front and back end
// depends on rsm_pkg
module rsm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rsm_pkg::rsm_job_t wr_job,
	output logic              full,
	input  logic              pop,
	output rsm_pkg::rsm_job_t rd_job,
	output logic              empty
);
	import rsm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	rsm_job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;

	assign full = cnt_q == CW'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rd_job = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_job;
	end
endmodule

// ----- rtl/rsm_back.sv -----
// back end: walks a job strip by strip and emits one segment a beat
// depends on rsm_pkg
module rsm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsm_pkg::rsm_cfg_t           cfg,
	input  logic                        q_empty,
	input  rsm_pkg::rsm_job_t           q_job,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [3:0]                  data_disk,
	output logic [3:0]                  parity_disk,
	output logic [rsm_pkg::ADDR_W-1:0]  physical_block,
	output logic [rsm_pkg::CNT_W-1:0]   segment_blocks,
	output logic [rsm_pkg::OFF_W-1:0]   strip_offset,
	output logic [rsm_pkg::REL_W-1:0]   stripe_relative,
	output logic [3:0]                  strips_in_stripe,
	output logic [1:0]                  partial_strips,
	output logic                        read_modify_write,
	output logic                        last
);
	import rsm_pkg::*;

	logic               act_q;
	rsm_job_t           job_q;
	logic [ADDR_W-1:0]  base_q;
	logic [OFF_W-1:0]   off_q;
	logic [CNT_W-1:0]   left_q;
	logic [DISK_W-1:0]  pos_q;
	logic [DISK_W-1:0]  rot_q;
	logic [REL_W-1:0]   rel_q;
	logic               ov_q;

	logic [DISK_W-1:0]  d;
	logic [DISK_W-1:0]  nm1;
	logic [STRIP_W-1:0] room;
	logic [CNT_W-1:0]   seg;
	logic [CNT_W-1:0]   left_n;
	logic [DISK_W-1:0]  pdisk;
	logic [DISK_W-1:0]  ddisk;
	logic [DISK_W:0]    nc_sum;
	logic [DISK_W-1:0]  si, ei;
	logic [OFF_W-1:0]   fo, lo;
	logic [DISK_W:0]    touched;
	logic [1:0]         parts;
	logic               emit;
	logic               first_st, last_st;

	assign d = DISK_W'(cfg.n - 1'b1);
	assign nm1 = d;
	assign room = cfg.sb - STRIP_W'(off_q);
	assign seg = (room < STRIP_W'(left_q)) ? room[CNT_W-1:0] : left_q;
	assign left_n = left_q - seg;
	assign nc_sum = (DISK_W + 1)'(pos_q) + (DISK_W + 1)'(pdisk) + 1'b1;

	always_comb begin
		unique case (cfg.mode)
			LAY_R4_FIRST: begin
				pdisk = '0;
				ddisk = pos_q + 1'b1;
			end
			LAY_R4_LAST: begin
				pdisk = nm1;
				ddisk = pos_q;
			end
			LAY_R5_0R: begin
				pdisk = rot_q;
				ddisk = (pos_q < pdisk) ? pos_q : pos_q + 1'b1;
			end
			LAY_R5_NR: begin
				pdisk = nm1 - rot_q;
				ddisk = (pos_q < pdisk) ? pos_q : pos_q + 1'b1;
			end
			default: begin
				pdisk = nm1 - rot_q;
				ddisk = (nc_sum >= (DISK_W + 1)'(cfg.n))
					? DISK_W'(nc_sum - (DISK_W + 1)'(cfg.n)) : nc_sum[DISK_W-1:0];
			end
		endcase
	end

	// stripe statistics from the request's first and last strip
	assign first_st = rel_q == '0;
	assign last_st = rel_q == job_q.last_rel;
	assign si = first_st ? job_q.pos0 : '0;
	assign fo = first_st ? job_q.off0 : '0;
	assign ei = last_st ? job_q.pos_last : d - 1'b1;
	assign lo = last_st ? job_q.lo_last : OFF_W'(cfg.sb - 1'b1);
	assign touched = (DISK_W + 1)'(ei) - (DISK_W + 1)'(si) + 1'b1;

	always_comb begin
		parts = 2'd0;
		if (fo != '0) parts = parts + 1'b1;
		if (STRIP_W'(lo) != cfg.sb - 1'b1) parts = parts + 1'b1;
		if (si == ei && parts == 2'd2) parts = 2'd1;
	end

	assign emit = act_q && (!ov_q || !out_stall);
	assign q_pop = !act_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (q_pop) act_q <= 1'b1;
			else if (emit && (job_q.status != ST_OK || left_n == '0)) act_q <= 1'b0;
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			base_q <= q_job.base;
			off_q <= q_job.off0;
			left_q <= q_job.cnt;
			pos_q <= q_job.pos0;
			rot_q <= q_job.rot0;
			rel_q <= '0;
		end else if (emit) begin
			left_q <= left_n;
			off_q <= '0;
			if (pos_q == d - 1'b1) begin
				pos_q <= '0;
				rel_q <= rel_q + 1'b1;
				base_q <= base_q + ADDR_W'(cfg.sb);
				rot_q <= (rot_q == nm1) ? '0 : rot_q + 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
		if (emit) begin
			status <= job_q.status;
			if (job_q.status != ST_OK) begin
				data_disk <= '0;
				parity_disk <= '0;
				physical_block <= '0;
				segment_blocks <= '0;
				strip_offset <= '0;
				stripe_relative <= '0;
				strips_in_stripe <= '0;
				partial_strips <= '0;
				read_modify_write <= 1'b0;
				last <= 1'b1;
			end else begin
				data_disk <= ddisk[3:0];
				parity_disk <= pdisk[3:0];
				physical_block <= base_q + ADDR_W'(off_q);
				segment_blocks <= seg;
				strip_offset <= off_q;
				stripe_relative <= rel_q;
				strips_in_stripe <= touched[3:0];
				partial_strips <= parts;
				read_modify_write <= touched < (DISK_W + 1)'(d >> 1);
				last <= left_n == '0;
			end
		end
	end

	assign out_valid = ov_q;
endmodule

// ----- rtl/raid_stripe_request_mapper_core.sv -----
// raid4/raid5 request mapper: the front end holds in_stall high while it works on a
// request (five divisions on one shared divider, each with start and hand-off, plus a
// shift-add and a push; a rejected request goes straight to the push), so it takes no
// new request until the last one is pushed; the back end then emits one segment per
// cycle while out_stall is low. a two-entry queue lets the next request start while
// segments drain. arst_n clears control state and loads register defaults.
module raid_stripe_request_mapper_core #(
	parameter int MAX_DISKS = rsm_pkg::DEF_MAX_DISKS,
	parameter int MAX_REQUEST_BLOCKS = rsm_pkg::DEF_MAX_REQUEST_BLOCKS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [5:0]                  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [rsm_pkg::ADDR_W-1:0]  start_block,
	input  logic [rsm_pkg::CNT_W-1:0]   block_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [3:0]                  data_disk,
	output logic [3:0]                  parity_disk,
	output logic [rsm_pkg::ADDR_W-1:0]  physical_block,
	output logic [rsm_pkg::CNT_W-1:0]   segment_blocks,
	output logic [rsm_pkg::OFF_W-1:0]   strip_offset,
	output logic [rsm_pkg::REL_W-1:0]   stripe_relative,
	output logic [3:0]                  strips_in_stripe,
	output logic [1:0]                  partial_strips,
	output logic                        read_modify_write,
	output logic                        last
);
	import rsm_pkg::*;

	rsm_cfg_t cfg_q;
	logic     wr_en;
	logic [2:0] idx;
	logic     q_push, q_pop, q_full, q_empty;
	rsm_job_t wr_job, rd_job;

	assign pready = 1'b1;
	assign idx = paddr[5:3];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n <= NUM_W'(3);
			cfg_q.sb <= STRIP_W'(128);
			cfg_q.mode <= LAY_R5_NR;
			cfg_q.doff <= '0;
			cfg_q.vol <= '0;
			cfg_q.ro <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_EXTENT: begin
					if (pwdata[4:0] < 5'd3) cfg_q.n <= NUM_W'(3);
					else if (NUM_W'(pwdata[4:0]) > NUM_W'(MAX_DISKS))
						cfg_q.n <= NUM_W'(MAX_DISKS);
					else cfg_q.n <= NUM_W'(pwdata[4:0]);
				end
				REG_STRIP: begin
					if (pwdata[16:0] < 17'd128) cfg_q.sb <= STRIP_W'(128);
					else if (pwdata[16:0] > 17'd65536) cfg_q.sb <= STRIP_W'(65536);
					else cfg_q.sb <= pwdata[16:0];
				end
				REG_LAYOUT: cfg_q.mode <= (pwdata[2:0] > LAY_R5_NC) ? LAY_R5_NC : pwdata[2:0];
				REG_DOFF: cfg_q.doff <= pwdata[31:0];
				REG_VOLUME: cfg_q.vol <= pwdata[ADDR_W-1:0];
				REG_RDONLY: cfg_q.ro <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_EXTENT: prdata = 64'(cfg_q.n);
			REG_STRIP: prdata = 64'(cfg_q.sb);
			REG_LAYOUT: prdata = 64'(cfg_q.mode);
			REG_DOFF: prdata = 64'(cfg_q.doff);
			REG_VOLUME: prdata = 64'(cfg_q.vol);
			REG_RDONLY: prdata = 64'(cfg_q.ro);
			default: prdata = '0;
		endcase
	end

	rsm_front #(.MAX_REQUEST_BLOCKS(MAX_REQUEST_BLOCKS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.start_block (start_block),
		.block_count (block_count),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (wr_job)
	);

	rsm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (q_pop),
		.rd_job (rd_job),
		.empty  (q_empty)
	);

	rsm_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.q_empty           (q_empty),
		.q_job             (rd_job),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.data_disk         (data_disk),
		.parity_disk       (parity_disk),
		.physical_block    (physical_block),
		.segment_blocks    (segment_blocks),
		.strip_offset      (strip_offset),
		.stripe_relative   (stripe_relative),
		.strips_in_stripe  (strips_in_stripe),
		.partial_strips    (partial_strips),
		.read_modify_write (read_modify_write),
		.last              (last)
	);

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last)
		else $error("error beat without last");

	a_seg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> segment_blocks != '0)
		else $error("empty segment");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");
endmodule
